>>> rtl/core/v3alu_pkg.sv
// Shared constants for the three-component fixed-point vector unit.
package v3alu_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MODE_W        = 4;
    localparam int STATUS_W      = 2;

    localparam logic [MODE_W-1:0] MODE_ADD    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SCALE  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIVIDE = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DOT    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CROSS  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_NORM   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LENGTH = 4'd7;
    localparam logic [MODE_W-1:0] MODE_LENSQ  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_NEGATE = 4'd9;
    localparam logic [MODE_W-1:0] MODE_EQUAL  = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;

endpackage

>>> rtl/core/vector3_fixed_point_alu_top.sv
// Pipelined three-component vector arithmetic unit in signed fixed point.
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------------------
// s (in)    input      i_s_tvalid / o_s_tready   i_s_tdata: a_x..b_z, scalar; tuser: mode
// m (out)   output     o_m_tvalid / i_m_tready   o_m_tdata: res_x..res_scalar, flag, status
//
// One word is taken in every cycle while the output buffer has room. On its way to the
// output register a word passes the square-root chain of WORD_BITS stages followed by the
// divider chain of WORD_BITS+FRAC_BITS stages, one result bit per stage. Reset clears only
// the valid bits and the output buffer count. The output holds up to two finished words, so
// the pipeline keeps moving while one result waits; it halts as a whole only when both are
// occupied.
module vector3_fixed_point_alu_top #(
    parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata from the lowest bit: a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, zero fill
    input  logic [((7*WORD_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: mode
    input  logic [v3alu_pkg::MODE_W-1:0]   i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata from the lowest bit: res_x, res_y, res_z, res_scalar, equal_flag, status,
    // zero fill
    output logic [((4*WORD_BITS+3+7)/8)*8-1:0] o_m_tdata
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int QW = W + F;
    localparam int OUT_W = ((4 * W + 3 + 7) / 8) * 8;

    // Stage indices along the pipeline.
    localparam int I_MUL  = 1;
    localparam int I_SUM  = 2;
    localparam int I_RND  = 3;
    localparam int I_SQ0  = 4;
    localparam int I_DSET = I_SQ0 + W;
    localparam int I_DV0  = I_DSET + 1;
    localparam int I_FIN  = I_DV0 + QW;
    localparam int NS     = I_FIN + 1;

    localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

    typedef struct packed {
        logic [v3alu_pkg::MODE_W-1:0]   mode;
        logic [2:0][W-1:0]              a;
        logic [2:0][W-1:0]              b;
        logic [W-1:0]                   s;
        logic [5:0][PW-1:0]             p;
        logic [3:0][SW-1:0]             w;
        logic [2:0][W-1:0]              v;
        logic [W-1:0]                   sc;
        logic                           eq;
        logic                           ovf;
        logic                           dz;
        logic [v3alu_pkg::STATUS_W-1:0] st;
        logic [PW-1:0]                  sq;
        logic [W+2:0]                   srem;
        logic [W-1:0]                   sroot;
        logic [PW-1:0]                  ssh;
        logic [W-1:0]                   dd;
        logic [2:0]                     dgo;
        logic [2:0]                     dneg;
        logic [2:0][W-1:0]              drem;
        logic [2:0][QW-1:0]             dq;
        logic [2:0][QW-1:0]             dn;
    } t_st;

    typedef struct packed {
        logic [v3alu_pkg::STATUS_W-1:0] st;
        logic                           eq;
        logic [W-1:0]                   sc;
        logic [W-1:0]                   z;
        logic [W-1:0]                   y;
        logic [W-1:0]                   x;
    } t_res;

    // Clamp a wide signed value to the word range; the top bit returned is the overflow.
    function automatic logic [W:0] f_sat(logic [SW-1:0] x);
        logic [SW-W:0] hi;
        hi = x[SW-1:W-1];
        if (hi == '0 || hi == {(SW-W+1){1'b1}}) begin
            return {1'b0, x[W-1:0]};
        end
        return {1'b1, (x[SW-1] ? MINV : MAXV)};
    endfunction

    // Add half an LSB, then arithmetic shift right by the fraction width.
    function automatic logic [SW-1:0] f_round(logic [SW-1:0] x);
        logic signed [SW-1:0] t;
        t = $signed(x + HALF);
        return t >>> F;
    endfunction

    function automatic t_st f_mul(t_st i);
        t_st                  o;
        logic [5:0][W-1:0]    ox;
        logic [5:0][W-1:0]    oy;
        logic signed [PW-1:0] pr;
        logic [SW-1:0]        e;
        logic [W:0]           r;
        o  = i;
        ox = '0;
        oy = '0;
        if (i.mode == v3alu_pkg::MODE_SCALE) begin
            for (int k = 0; k < 3; k++) begin
                ox[k] = i.a[k];
                oy[k] = i.s;
            end
        end else if (i.mode == v3alu_pkg::MODE_DOT) begin
            for (int k = 0; k < 3; k++) begin
                ox[k] = i.a[k];
                oy[k] = i.b[k];
            end
        end else if (i.mode inside {v3alu_pkg::MODE_NORM, v3alu_pkg::MODE_LENGTH,
                                    v3alu_pkg::MODE_LENSQ}) begin
            for (int k = 0; k < 3; k++) begin
                ox[k] = i.a[k];
                oy[k] = i.a[k];
            end
        end else if (i.mode == v3alu_pkg::MODE_CROSS) begin
            ox[0] = i.a[1]; oy[0] = i.b[2];
            ox[1] = i.a[2]; oy[1] = i.b[1];
            ox[2] = i.a[2]; oy[2] = i.b[0];
            ox[3] = i.a[0]; oy[3] = i.b[2];
            ox[4] = i.a[0]; oy[4] = i.b[1];
            ox[5] = i.a[1]; oy[5] = i.b[0];
        end
        for (int k = 0; k < 6; k++) begin
            pr     = $signed(ox[k]) * $signed(oy[k]);
            o.p[k] = pr;
        end
        if (i.mode inside {v3alu_pkg::MODE_ADD, v3alu_pkg::MODE_SUB,
                           v3alu_pkg::MODE_NEGATE}) begin
            for (int k = 0; k < 3; k++) begin
                if (i.mode == v3alu_pkg::MODE_ADD) begin
                    e = SW'($signed(i.a[k])) + SW'($signed(i.b[k]));
                end else if (i.mode == v3alu_pkg::MODE_SUB) begin
                    e = SW'($signed(i.a[k])) - SW'($signed(i.b[k]));
                end else begin
                    e = -SW'($signed(i.a[k]));
                end
                r      = f_sat(e);
                o.v[k] = r[W-1:0];
                o.ovf  = o.ovf | r[W];
            end
        end
        o.eq = (i.mode == v3alu_pkg::MODE_EQUAL) && (i.a == i.b);
        return o;
    endfunction

    function automatic t_st f_sum(t_st i);
        t_st o;
        o = i;
        for (int k = 0; k < 3; k++) begin
            if (i.mode == v3alu_pkg::MODE_CROSS) begin
                o.w[k] = SW'($signed(i.p[2*k])) - SW'($signed(i.p[2*k+1]));
            end else begin
                o.w[k] = SW'($signed(i.p[k]));
            end
        end
        o.w[3] = SW'($signed(i.p[0])) + SW'($signed(i.p[1])) + SW'($signed(i.p[2]));
        return o;
    endfunction

    function automatic t_st f_rnd(t_st i);
        t_st        o;
        logic [W:0] r;
        o = i;
        if (i.mode inside {v3alu_pkg::MODE_SCALE, v3alu_pkg::MODE_CROSS}) begin
            for (int k = 0; k < 3; k++) begin
                r      = f_sat(f_round(i.w[k]));
                o.v[k] = r[W-1:0];
                o.ovf  = o.ovf | r[W];
            end
        end
        if (i.mode inside {v3alu_pkg::MODE_DOT, v3alu_pkg::MODE_LENSQ}) begin
            r     = f_sat(f_round(i.w[3]));
            o.sc  = r[W-1:0];
            o.ovf = o.ovf | r[W];
        end
        o.sq    = i.w[3][PW-1:0];
        o.ssh   = i.w[3][PW-1:0];
        o.srem  = '0;
        o.sroot = '0;
        return o;
    endfunction

    // One bit of the integer square root, two radicand bits consumed per step.
    function automatic t_st f_sqrt(t_st i);
        t_st          o;
        logic [W+2:0] r2;
        logic [W+2:0] tr;
        o     = i;
        r2    = {i.srem[W:0], i.ssh[PW-1 -: 2]};
        tr    = {1'b0, i.sroot, 2'b01};
        o.ssh = i.ssh << 2;
        if (r2 >= tr) begin
            o.srem  = r2 - tr;
            o.sroot = {i.sroot[W-2:0], 1'b1};
        end else begin
            o.srem  = r2;
            o.sroot = {i.sroot[W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_st f_dset(t_st i);
        t_st          o;
        logic [W-1:0] m;
        o      = i;
        o.dgo  = '0;
        o.drem = '0;
        o.dq   = '0;
        for (int k = 0; k < 3; k++) begin
            m         = i.a[k][W-1] ? (~i.a[k] + W'(1)) : i.a[k];
            o.dn[k]   = {m, {F{1'b0}}};
            o.dneg[k] = i.a[k][W-1];
        end
        if (i.mode == v3alu_pkg::MODE_LENGTH) begin
            if (i.sroot[W-1]) begin
                o.sc  = MAXV;
                o.ovf = 1'b1;
            end else begin
                o.sc = i.sroot;
            end
        end else if (i.mode == v3alu_pkg::MODE_NORM) begin
            if (i.sq == '0) begin
                o.v = i.a;
            end else begin
                o.dd  = i.sroot;
                o.dgo = 3'b111;
            end
        end else if (i.mode == v3alu_pkg::MODE_DIVIDE) begin
            if (i.s == '0) begin
                o.dz = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (i.a[k] == '0) begin
                        o.v[k] = '0;
                    end else begin
                        o.v[k] = i.a[k][W-1] ? MINV : MAXV;
                    end
                end
            end else begin
                o.dd  = i.s[W-1] ? (~i.s + W'(1)) : i.s;
                o.dgo = 3'b111;
                for (int k = 0; k < 3; k++) begin
                    o.dneg[k] = i.a[k][W-1] ^ i.s[W-1];
                end
            end
        end
        return o;
    endfunction

    // One restoring division step in each of the three lanes.
    function automatic t_st f_div(t_st i);
        t_st        o;
        logic [W:0] r2;
        logic [W:0] df;
        logic       qb;
        o = i;
        for (int k = 0; k < 3; k++) begin
            r2 = {i.drem[k], i.dn[k][QW-1]};
            qb = (r2 >= {1'b0, i.dd});
            df = r2 - {1'b0, i.dd};
            o.drem[k] = qb ? df[W-1:0] : r2[W-1:0];
            o.dq[k]   = {i.dq[k][QW-2:0], qb};
            o.dn[k]   = i.dn[k] << 1;
        end
        return o;
    endfunction

    function automatic t_st f_fin(t_st i);
        t_st           o;
        logic [SW-1:0] e;
        logic [W:0]    r;
        o = i;
        for (int k = 0; k < 3; k++) begin
            if (i.dgo[k]) begin
                e      = SW'(i.dq[k]);
                e      = i.dneg[k] ? -e : e;
                r      = f_sat(e);
                o.v[k] = r[W-1:0];
                o.ovf  = o.ovf | r[W];
            end
        end
        if (o.dz) begin
            o.st = v3alu_pkg::ST_DIVZERO;
        end else if (o.ovf) begin
            o.st = v3alu_pkg::ST_SAT;
        end else begin
            o.st = v3alu_pkg::ST_OK;
        end
        return o;
    endfunction

    t_st   r_pipe [NS];
    t_st   n_pipe [NS];
    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;

    // Two-word output buffer: r_out is the head shown on the port, r_skid the second word.
    t_res       r_out;
    t_res       n_out;
    t_res       r_skid;
    t_res       n_skid;
    t_res       w_fin;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_en;
    logic       w_push;
    logic       w_pop;

    assign w_en       = (r_cnt != 2'd2);
    assign o_s_tready = w_en;
    assign w_push     = w_en && r_valid[I_FIN];
    assign w_pop      = (r_cnt != 2'd0) && i_m_tready;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = OUT_W'(r_out);

    always_comb begin
        n_pipe[0]      = '0;
        n_pipe[0].mode = i_s_tuser;
        for (int k = 0; k < 3; k++) begin
            n_pipe[0].a[k] = i_s_tdata[k*W +: W];
            n_pipe[0].b[k] = i_s_tdata[(k+3)*W +: W];
        end
        n_pipe[0].s = i_s_tdata[6*W +: W];
        for (int k = 1; k < NS; k++) begin
            if (k == I_MUL) begin
                n_pipe[k] = f_mul(r_pipe[k-1]);
            end else if (k == I_SUM) begin
                n_pipe[k] = f_sum(r_pipe[k-1]);
            end else if (k == I_RND) begin
                n_pipe[k] = f_rnd(r_pipe[k-1]);
            end else if (k < I_DSET) begin
                n_pipe[k] = f_sqrt(r_pipe[k-1]);
            end else if (k == I_DSET) begin
                n_pipe[k] = f_dset(r_pipe[k-1]);
            end else if (k < I_FIN) begin
                n_pipe[k] = f_div(r_pipe[k-1]);
            end else begin
                n_pipe[k] = f_fin(r_pipe[k-1]);
            end
        end
        n_valid = {r_valid[NS-2:0], i_s_tvalid};
    end

    always_comb begin
        w_fin.x  = r_pipe[I_FIN].v[0];
        w_fin.y  = r_pipe[I_FIN].v[1];
        w_fin.z  = r_pipe[I_FIN].v[2];
        w_fin.sc = r_pipe[I_FIN].sc;
        w_fin.eq = r_pipe[I_FIN].eq;
        w_fin.st = r_pipe[I_FIN].st;
    end

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        n_cnt  = r_cnt;
        case (r_cnt)
            2'd0: begin
                if (w_push) begin
                    n_out = w_fin;
                    n_cnt = 2'd1;
                end
            end
            2'd1: begin
                if (w_push && w_pop) begin
                    n_out = w_fin;
                end else if (w_pop) begin
                    n_cnt = 2'd0;
                end else if (w_push) begin
                    n_skid = w_fin;
                    n_cnt  = 2'd2;
                end
            end
            2'd2: begin
                if (w_pop) begin
                    n_out = r_skid;
                    n_cnt = 2'd1;
                end
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_en) begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (w_en) begin
            r_pipe <= n_pipe;
        end
    end

    // A finished word held back by a full buffer is still there on the next cycle.
    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[I_FIN] && !w_en) |=> r_valid[I_FIN])
        else $error("finished word dropped while the output buffer was full");

    // A full buffer stays full until the head word is taken.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_m_tready) |=> (r_cnt == 2'd2))
        else $error("output buffer lost a word while stalled");

    // An equality result never carries a fault status.
    a_eq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[I_FIN] && r_pipe[I_FIN].eq) |-> (r_pipe[I_FIN].st == v3alu_pkg::ST_OK))
        else $error("equality result with non-zero status");

endmodule

>>> tb/vector3_fixed_point_alu_top_tb.sv
// Self-checking testbench for the three-component fixed-point vector unit.
module vector3_fixed_point_alu_top_tb;

    localparam int WB = v3alu_pkg::WORD_BITS_DEF;
    localparam int FB = v3alu_pkg::FRAC_BITS_DEF;
    localparam int IN_W = ((7*WB+7)/8)*8;
    localparam int OUT_W = ((4*WB+3+7)/8)*8;
    localparam int LATENCY = 2*WB+FB+6;

    typedef struct packed {
        logic [1:0]  status;
        logic        eq;
        logic [31:0] sc;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } vec_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic [v3alu_pkg::MODE_W-1:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    // Idle percentages for the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;
    int unsigned word_count = 0;
    vec_result_t expected_results[$];

    vector3_fixed_point_alu_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a wide signed value to the 32-bit range, flagging an overflow.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Round half up, then drop the fraction bits.
    function automatic logic signed [127:0] round_frac(input logic signed [127:0] v);
        return (v + (128'sd1 <<< (FB-1))) >>> FB;
    endfunction

    // Quotient of a shifted left by the fraction bits over d, truncated toward zero.
    function automatic logic [31:0] fixed_div(input logic signed [127:0] a,
                                              input logic signed [127:0] d, inout bit ovf);
        logic signed [127:0] q;
        q = (a <<< FB) / d;
        return clamp32(q, ovf);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 50; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s) r = t;
        end
        return r;
    endfunction

    // Work out the result of one input word.
    function automatic vec_result_t vector_result(input logic [v3alu_pkg::MODE_W-1:0] mode,
                                                  input logic [7*WB-1:0] d);
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] s;
        logic signed [127:0] sq;
        logic signed [127:0] t;
        logic [31:0] v[3];
        logic [31:0] sc;
        logic [63:0] len;
        bit ovf;
        bit dz;
        vec_result_t r;
        ovf = 0;
        dz = 0;
        sc = '0;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(d[i*WB +: WB]);
            b[i] = $signed(d[(i+3)*WB +: WB]);
            v[i] = '0;
        end
        s = $signed(d[6*WB +: WB]);
        sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        case (mode)
            v3alu_pkg::MODE_ADD:
                for (int i = 0; i < 3; i++) v[i] = clamp32(a[i] + b[i], ovf);
            v3alu_pkg::MODE_SUB:
                for (int i = 0; i < 3; i++) v[i] = clamp32(a[i] - b[i], ovf);
            v3alu_pkg::MODE_NEGATE:
                for (int i = 0; i < 3; i++) v[i] = clamp32(-a[i], ovf);
            v3alu_pkg::MODE_SCALE:
                for (int i = 0; i < 3; i++) v[i] = clamp32(round_frac(a[i]*s), ovf);
            v3alu_pkg::MODE_DIVIDE:
                for (int i = 0; i < 3; i++) begin
                    if (s == 0) begin
                        dz = 1;
                        v[i] = a[i] > 0 ? 32'h7fffffff : a[i] < 0 ? 32'h80000000 : 32'h0;
                    end else begin
                        v[i] = fixed_div(a[i], s, ovf);
                    end
                end
            v3alu_pkg::MODE_DOT:
                sc = clamp32(round_frac(a[0]*b[0] + a[1]*b[1] + a[2]*b[2]), ovf);
            v3alu_pkg::MODE_CROSS:
                for (int i = 0; i < 3; i++) begin
                    t = a[(i+1)%3]*b[(i+2)%3] - a[(i+2)%3]*b[(i+1)%3];
                    v[i] = clamp32(round_frac(t), ovf);
                end
            v3alu_pkg::MODE_NORM:
                if (sq == 0) begin
                    for (int i = 0; i < 3; i++) v[i] = a[i][31:0];
                end else begin
                    len = floor_sqrt(sq);
                    for (int i = 0; i < 3; i++)
                        v[i] = fixed_div(a[i], $signed({64'd0, len}), ovf);
                end
            v3alu_pkg::MODE_LENGTH: begin
                len = floor_sqrt(sq);
                sc = clamp32($signed({64'd0, len}), ovf);
            end
            v3alu_pkg::MODE_LENSQ:  sc = clamp32(round_frac(sq), ovf);
            v3alu_pkg::MODE_EQUAL:
                r.eq = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]);
            default: ;
        endcase
        r.x = v[0];
        r.y = v[1];
        r.z = v[2];
        r.sc = sc;
        r.status = dz ? v3alu_pkg::ST_DIVZERO : (ovf ? v3alu_pkg::ST_SAT : v3alu_pkg::ST_OK);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("result %0d: %s got %h expected %h", result_count, what, got, want);
    endtask

    // Send one word, idling beforehand at random, and queue its expected result.
    task automatic send_word(input logic [v3alu_pkg::MODE_W-1:0] mode,
                             input logic [7*WB-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= IN_W'(d);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_results.push_back(vector_result(mode, d));
        word_count++;
    endtask

    // Receiver: random stalls, and each accepted word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        vec_result_t got;
        vec_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[$bits(vec_result_t)-1:0];
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", got.x, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (got.x !== want.x) report_mismatch("res_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("res_y", got.y, want.y);
                if (got.z !== want.z) report_mismatch("res_z", got.z, want.z);
                if (got.sc !== want.sc) report_mismatch("res_scalar", got.sc, want.sc);
                if (got.eq !== want.eq)
                    report_mismatch("equal_flag", 32'(got.eq), 32'(want.eq));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] rand_comp(input int unsigned kind);
        case (kind % 6)
            0: return $urandom();
            1: return 32'($signed($urandom_range(65536*8)) - 65536*4);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3: return 32'h0;
            4: return 32'($urandom_range(255)) << 16;
            default: return 32'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic logic [7*WB-1:0] pack_vectors(input logic [31:0] ax, ay, az,
                                                     bx, by, bz, s);
        return {s, bz, by, bx, az, ay, ax};
    endfunction

    // Extremes in every mode, and the special cases of several operations.
    task automatic test_directed();
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        for (int m = v3alu_pkg::MODE_ADD; m <= v3alu_pkg::MODE_EQUAL; m++)
            send_word(v3alu_pkg::MODE_W'(m),
                      pack_vectors(mx, mn, 32'h10000, mx, mn, 32'hffff0000, mx));
        send_word(v3alu_pkg::MODE_NEGATE, pack_vectors(mn, 0, 1, 0, 0, 0, 0));
        send_word(v3alu_pkg::MODE_DIVIDE, pack_vectors(5, 32'hfffffffb, 0, 0, 0, 0, 0));
        send_word(v3alu_pkg::MODE_DIVIDE, pack_vectors(mn, mx, 3, 0, 0, 0, 32'hffffffff));
        send_word(v3alu_pkg::MODE_NORM, pack_vectors(0, 0, 0, 0, 0, 0, 0));
        send_word(v3alu_pkg::MODE_NORM, pack_vectors(mn, mn, mn, 0, 0, 0, 0));
        send_word(v3alu_pkg::MODE_NORM, pack_vectors(1, 0, 0, 0, 0, 0, 0));
        send_word(v3alu_pkg::MODE_LENGTH, pack_vectors(mn, mn, mn, 0, 0, 0, 0));
        send_word(v3alu_pkg::MODE_SCALE,
                  pack_vectors(32'h8000, 32'hffff8000, 1, 0, 0, 0, 32'h1));
        send_word(v3alu_pkg::MODE_EQUAL, pack_vectors(7, 8, 9, 7, 8, 9, 0));
        send_word(v3alu_pkg::MODE_EQUAL, pack_vectors(7, 8, 9, 7, 8, 10, 0));
        send_word(4'd11, pack_vectors(mx, mx, mx, mx, mx, mx, mx));
        send_word(4'd15, pack_vectors(mn, mn, mn, mn, mn, mn, mn));
        send_word(v3alu_pkg::MODE_CROSS,
                  pack_vectors(32'hffffffff, 0, 32'hffffffff, 0, 32'hffffffff,
                               32'hffffffff, 32'hffffffff));
    endtask

    task automatic test_random(input int unsigned n);
        logic [31:0] c[7];
        logic [v3alu_pkg::MODE_W-1:0] mode;
        for (int unsigned k = 0; k < n; k++) begin
            for (int i = 0; i < 7; i++) c[i] = rand_comp($urandom());
            // Equal mode often gets matching vectors so that both flag values occur.
            mode = ($urandom_range(19) == 0) ? v3alu_pkg::MODE_W'($urandom_range(11, 15))
                                              : v3alu_pkg::MODE_W'($urandom_range(10));
            if (mode == v3alu_pkg::MODE_EQUAL && $urandom_range(1)) begin
                c[3] = c[0];
                c[4] = c[1];
                c[5] = c[2];
            end
            send_word(mode, pack_vectors(c[0], c[1], c[2], c[3], c[4], c[5], c[6]));
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 13;
        recv_idle_pct = 78;
        test_directed();
        test_random(600);
        send_idle_pct = 78;
        recv_idle_pct = 13;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(625);
        i_s_tvalid <= 1'b0;
        wait_drained();
        $display("Sent %0d words over all eleven operations and unused modes;", word_count);
        $display("checked %0d results under three idling patterns.", result_count);
        if (mismatch_count == 0) begin
            $display("vector3_fixed_point_alu_top: match");
        end else begin
            $display("vector3_fixed_point_alu_top: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("vector3_fixed_point_alu_top: mismatch");
        $finish;
    end
endmodule
